[design/fdr_pkg.sv]
// Shared widths, constants and types of the Fresnel reflectance pipeline.
`timescale 1ns / 1ps
package fdr_pkg;

  localparam int IDX_W   = 16;  // refractive index, Q4.12
  localparam int COS_W   = 18;  // incoming cosine, signed Q1.16
  localparam int C_W     = 17;  // cosine magnitude, Q16
  localparam int SQ_W    = 32;  // squared index, index times cosine
  localparam int CSQ_W   = 33;  // squared cosine, Q32
  localparam int D_W     = 64;  // radicand
  localparam int ROOT_W  = 32;  // square root
  localparam int REM_W   = 36;  // square root remainder
  localparam int PROD_W  = 48;  // ratio operands
  localparam int SUM_W   = 49;  // ratio operand sum
  localparam int Q_W     = 32;  // ratio quotient, Q31
  localparam int DREM_W  = 33;  // divider remainder
  localparam int SQR_W   = 64;  // squared quotients
  localparam int REFL_W  = 17;  // reflectance, Q1.16
  localparam int TDATA_W = 24;  // stream data width

  localparam int SQRT_STAGES = ROOT_W;
  localparam int NORM_STAGES = 17;
  localparam int DIV_STAGES  = Q_W;

  localparam logic [C_W-1:0]    COS_ONE  = 17'h1_0000;
  localparam logic [REFL_W-1:0] REFL_ONE = 17'h1_0000;
  localparam logic [Q_W-1:0]    Q_ONE    = 32'h8000_0000;
  localparam logic [SQR_W-1:0]  SQ_ROUND = 64'h0000_4000_0000_0000;

  typedef enum logic {
    REG_INCIDENT    = 1'b0,
    REG_TRANSMITTED = 1'b1
  } cfg_reg_t;

  // Data riding alongside the square root.
  typedef struct packed {
    logic              tir;
    logic [PROD_W-1:0] a;
    logic [SQ_W-1:0]   cp;
    logic [IDX_W-1:0]  ni;
  } sqrt_side_t;

endpackage

[design/fdr_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module fdr_sqrt import fdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [D_W-1:0]    in_rad,
  input  sqrt_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output sqrt_side_t        out_side
);

  logic              v_r    [SQRT_STAGES];
  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];
  logic [D_W-1:0]    rad_r  [SQRT_STAGES];
  sqrt_side_t        side_r [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_st
    logic              v_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [D_W-1:0]    rad_in;
    sqrt_side_t        side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
      assign side_in = side_r[j-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[D_W-1 -: 2]};
      trial  = {2'b00, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        rad_r[j]  <= {rad_in[D_W-3:0], 2'b00};
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = v_r[SQRT_STAGES-1];
  assign out_root  = root_r[SQRT_STAGES-1];
  assign out_side  = side_r[SQRT_STAGES-1];

endmodule

[design/fdr_ratio.sv]
// Pipelined |x-y|/(x+y) in Q31: operand normalize, then one quotient bit per stage.
`timescale 1ns / 1ps
module fdr_ratio import fdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [PROD_W-1:0] in_x,
  input  logic [PROD_W-1:0] in_y,
  input  logic              in_tag,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_q,
  output logic              out_tag
);

  // normalize stages
  logic              nv_r   [NORM_STAGES];
  logic [PROD_W-1:0] nx_r   [NORM_STAGES];
  logic [PROD_W-1:0] ny_r   [NORM_STAGES];
  logic              ntag_r [NORM_STAGES];

  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    logic              v_in;
    logic [PROD_W-1:0] x_in;
    logic [PROD_W-1:0] y_in;
    logic              tag_in;
    logic [SUM_W-1:0]  s;
    logic              big;

    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign x_in   = in_x;
      assign y_in   = in_y;
      assign tag_in = in_tag;
    end else begin : g_next
      assign v_in   = nv_r[j-1];
      assign x_in   = nx_r[j-1];
      assign y_in   = ny_r[j-1];
      assign tag_in = ntag_r[j-1];
    end

    assign s   = {1'b0, x_in} + {1'b0, y_in};
    assign big = |s[SUM_W-1:Q_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[j] <= 1'b0;
      end else if (en) begin
        nv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[j]   <= big ? (x_in >> 1) : x_in;
        ny_r[j]   <= big ? (y_in >> 1) : y_in;
        ntag_r[j] <= tag_in;
      end
    end
  end

  // sum and difference, now below 2^32
  logic              pv_r;
  logic [Q_W-1:0]    ps_r;
  logic [Q_W-1:0]    pd_r;
  logic              pz_r;
  logic              ptag_r;
  logic [PROD_W-1:0] lx;
  logic [PROD_W-1:0] ly;
  logic [PROD_W-1:0] lsum;
  logic [PROD_W-1:0] ldif;

  assign lx   = nx_r[NORM_STAGES-1];
  assign ly   = ny_r[NORM_STAGES-1];
  assign lsum = lx + ly;
  assign ldif = (lx > ly) ? (lx - ly) : (ly - lx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= nv_r[NORM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r   <= lsum[Q_W-1:0];
      pd_r   <= ldif[Q_W-1:0];
      pz_r   <= (lsum == '0);
      ptag_r <= ntag_r[NORM_STAGES-1];
    end
  end

  // restoring divide
  logic              dv_r   [DIV_STAGES];
  logic [DREM_W-1:0] drem_r [DIV_STAGES];
  logic [Q_W-1:0]    dq_r   [DIV_STAGES];
  logic [Q_W-1:0]    ds_r   [DIV_STAGES];
  logic              dz_r   [DIV_STAGES];
  logic              dtag_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic              v_in;
    logic [DREM_W-1:0] rem_in;
    logic [Q_W-1:0]    q_in;
    logic [Q_W-1:0]    s_in;
    logic              z_in;
    logic              tag_in;
    logic [DREM_W-1:0] rem_a;
    logic [DREM_W:0]   diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in   = pv_r;
      assign rem_in = {1'b0, pd_r};
      assign q_in   = '0;
      assign s_in   = ps_r;
      assign z_in   = pz_r;
      assign tag_in = ptag_r;
      assign rem_a  = rem_in;
    end else begin : g_next
      assign v_in   = dv_r[j-1];
      assign rem_in = drem_r[j-1];
      assign q_in   = dq_r[j-1];
      assign s_in   = ds_r[j-1];
      assign z_in   = dz_r[j-1];
      assign tag_in = dtag_r[j-1];
      assign rem_a  = {rem_in[DREM_W-2:0], 1'b0};
    end

    assign diff = {1'b0, rem_a} - {2'b00, s_in};
    assign ge   = !diff[DREM_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= ge ? diff[DREM_W-1:0] : rem_a;
        dq_r[j]   <= {q_in[Q_W-2:0], ge};
        ds_r[j]   <= s_in;
        dz_r[j]   <= z_in;
        dtag_r[j] <= tag_in;
      end
    end
  end

  // both operands zero: ratio magnitude is one
  assign out_valid = dv_r[DIV_STAGES-1];
  assign out_q     = dz_r[DIV_STAGES-1] ? Q_ONE : dq_r[DIV_STAGES-1];
  assign out_tag   = dtag_r[DIV_STAGES-1];

endmodule

[design/fresnel_dielectric_reflectance.sv]
// Top level of the unpolarized dielectric Fresnel reflectance pipeline.
`timescale 1ns / 1ps
// Streams one cosine of incidence (signed Q1.16) per transaction and returns
// the unpolarized Fresnel reflectance (Q1.16, 65536 = 1.0) plus a total
// internal reflection flag in tuser. A cosine of zero or below means the ray
// is leaving: the two indices swap and the magnitude is used; values beyond
// one clamp. Fully pipelined: a new transaction every cycle while in_tready
// is high. Each cosine passes through the 32-stage square root and then the two
// 50-stage ratio dividers (17 normalize, 1 setup, 32 quotient stages) running
// side by side. The pipeline advances as a whole; an output register plus a
// one-entry skid buffer let it keep taking input while a result waits, and
// in_tready drops only once the skid entry is occupied. Index registers are
// written over cfg_* (index 0 incident, 1 transmitted, reset 1.0 in Q4.12)
// and must only change while the pipeline is empty.
module fresnel_dielectric_reflectance import fdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // config write port
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [IDX_W-1:0]   cfg_wdata,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [17:0] cos_incident
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [16:0] reflectance
  output logic               out_tuser   // [0] total_reflection
);

  // ---------------- config registers ----------------
  logic [IDX_W-1:0] inc_r;
  logic [IDX_W-1:0] trn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= 16'd4096;
      trn_r <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_INCIDENT:    inc_r <= cfg_wdata;
        REG_TRANSMITTED: trn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en;
  logic accept;
  logic skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  // ---------------- stage 1: clamp, direction, index swap ----------------
  logic [COS_W-1:0] cs;
  logic [COS_W-1:0] mag;
  logic             entering;
  logic             v1_r;
  logic [C_W-1:0]   c1_r;
  logic [IDX_W-1:0] ni1_r;
  logic [IDX_W-1:0] nt1_r;

  assign cs       = in_tdata[COS_W-1:0];
  assign mag      = cs[COS_W-1] ? (~cs + 1'b1) : cs;
  assign entering = !cs[COS_W-1] && (cs != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= (mag > {1'b0, COS_ONE}) ? COS_ONE : mag[C_W-1:0];
      ni1_r <= entering ? inc_r : trn_r;
      nt1_r <= entering ? trn_r : inc_r;
    end
  end

  // ---------------- stage 2: squares ----------------
  logic [SQ_W-1:0]  ni_sq;
  logic [SQ_W-1:0]  nt_sq;
  logic [2*C_W-1:0] c_sq;
  logic             v2_r;
  logic [SQ_W-1:0]  ni2_r;
  logic [SQ_W-1:0]  nt2_r;
  logic [CSQ_W-1:0] c2_r;
  logic [C_W-1:0]   c2c_r;
  logic [IDX_W-1:0] ni2i_r;

  assign ni_sq = ni1_r * ni1_r;
  assign nt_sq = nt1_r * nt1_r;
  assign c_sq  = c1_r * c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ni2_r  <= ni_sq;
      nt2_r  <= nt_sq;
      c2_r   <= c_sq[CSQ_W-1:0];
      c2c_r  <= c1_r;
      ni2i_r <= ni1_r;
    end
  end

  // ---------------- stage 3: products ----------------
  // c^2 is either exactly 2^32 or below it, so ni^2*c^2 is a select.
  logic [D_W-1:0]       p_mul;
  logic [SQ_W+C_W-1:0]  a_mul;
  logic [IDX_W+C_W-1:0] cp_mul;
  logic                 v3_r;
  logic [D_W-1:0]       p3_r;
  logic [SQ_W-1:0]      ni3_sq_r;
  logic [SQ_W-1:0]      nt3_sq_r;
  logic [PROD_W-1:0]    a3_r;
  logic [SQ_W-1:0]      cp3_r;
  logic [IDX_W-1:0]     ni3_r;

  assign p_mul  = c2_r[CSQ_W-1] ? {ni2_r, {SQ_W{1'b0}}} : (ni2_r * c2_r[SQ_W-1:0]);
  assign a_mul  = nt2_r * c2c_r;
  assign cp_mul = ni2i_r * c2c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r     <= p_mul;
      ni3_sq_r <= ni2_r;
      nt3_sq_r <= nt2_r;
      a3_r     <= a_mul[PROD_W-1:0];
      cp3_r    <= cp_mul[SQ_W-1:0];
      ni3_r    <= ni2i_r;
    end
  end

  // ---------------- stage 4: Snell test and radicand ----------------
  // lhs = ni^2 * sin^2 (Q8.56), rhs = nt^2 (Q8.56); TIR when lhs >= rhs.
  logic [D_W-1:0]  lhs;
  logic [D_W:0]    rad_diff;
  logic            v4_r;
  logic [D_W-1:0]  rad4_r;
  sqrt_side_t      side4_r;

  assign lhs      = {ni3_sq_r, {SQ_W{1'b0}}} - p3_r;
  assign rad_diff = {1'b0, nt3_sq_r, {SQ_W{1'b0}}} - {1'b0, lhs};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad4_r      <= rad_diff[D_W-1:0];
      side4_r.tir <= rad_diff[D_W] || (rad_diff[D_W-1:0] == '0);
      side4_r.a   <= a3_r;
      side4_r.cp  <= cp3_r;
      side4_r.ni  <= ni3_r;
    end
  end

  // ---------------- square root ----------------
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_side;

  fdr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_rad    (rad4_r),
    .in_side   (side4_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // ---------------- stage 5: B = ni * E ----------------
  logic [IDX_W+ROOT_W-1:0] b_mul;
  logic                    v5_r;
  logic [PROD_W-1:0]       a5_r;
  logic [PROD_W-1:0]       b5_r;
  logic [SQ_W-1:0]         cp5_r;
  logic [ROOT_W-1:0]       e5_r;
  logic                    tir5_r;

  assign b_mul = sq_side.ni * sq_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5_r   <= sq_side.a;
      b5_r   <= b_mul[PROD_W-1:0];
      cp5_r  <= sq_side.cp;
      e5_r   <= sq_root;
      tir5_r <= sq_side.tir;
    end
  end

  // ---------------- amplitude ratios ----------------
  logic           ra_v;
  logic           rb_v;
  logic [Q_W-1:0] qpar;
  logic [Q_W-1:0] qperp;
  logic           ra_tag;
  logic           rb_tag;

  fdr_ratio u_ratio_par (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_x      (a5_r),
    .in_y      (b5_r),
    .in_tag    (tir5_r),
    .out_valid (ra_v),
    .out_q     (qpar),
    .out_tag   (ra_tag)
  );

  fdr_ratio u_ratio_perp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_x      ({{(PROD_W-SQ_W){1'b0}}, cp5_r}),
    .in_y      ({{(PROD_W-ROOT_W){1'b0}}, e5_r}),
    .in_tag    (tir5_r),
    .out_valid (rb_v),
    .out_q     (qperp),
    .out_tag   (rb_tag)
  );

  // ---------------- stage 6: squared ratios ----------------
  logic             v6_r;
  logic [SQR_W-1:0] sqa6_r;
  logic [SQR_W-1:0] sqb6_r;
  logic             tir6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= ra_v && rb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa6_r <= qpar * qpar;
      sqb6_r <= qperp * qperp;
      tir6_r <= ra_tag || rb_tag;
    end
  end

  // ---------------- stage 7: mean, round, saturate ----------------
  logic [SQR_W-1:0]  msum;
  logic [REFL_W-1:0] mres;
  logic              v7_r;
  logic [REFL_W-1:0] refl7_r;
  logic              tir7_r;

  assign msum = sqa6_r + sqb6_r + SQ_ROUND;
  assign mres = msum[SQR_W-1 -: REFL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refl7_r <= (tir6_r || (mres > REFL_ONE)) ? REFL_ONE : mres;
      tir7_r  <= tir6_r;
    end
  end

  // ---------------- output register and skid buffer ----------------
  logic              arrive;
  logic              take;
  logic              out_v_r;
  logic [REFL_W-1:0] out_refl_r;
  logic              out_tir_r;
  logic [REFL_W-1:0] skid_refl_r;
  logic              skid_tir_r;

  assign arrive = en && v7_r;
  assign take   = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || take) begin
      out_v_r  <= skid_v_r || arrive;
      skid_v_r <= 1'b0;
    end else if (arrive) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_refl_r <= skid_refl_r;
        out_tir_r  <= skid_tir_r;
      end else if (arrive) begin
        out_refl_r <= refl7_r;
        out_tir_r  <= tir7_r;
      end
    end else if (arrive) begin
      skid_refl_r <= refl7_r;
      skid_tir_r  <= tir7_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(TDATA_W-REFL_W){1'b0}}, out_refl_r};
  assign out_tuser  = out_tir_r;

`ifndef SYNTHESIS
  // skid entry only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid buffer holds data while output register is empty");

  // reflectance never exceeds one
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_refl_r <= REFL_ONE))
    else $error("reflectance above 1.0");

  // total reflection always reports exactly one
  a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_tir_r) |-> (out_refl_r == REFL_ONE))
    else $error("total reflection with reflectance below 1.0");

  // the two ratio dividers stay in lockstep
  a_ratio_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ra_v == rb_v)
    else $error("ratio pipelines out of step");
`endif

endmodule

[tb/fdr_scoreboard.sv]
// Checker for the Fresnel reflectance block: predicts each result and compares.
`timescale 1ns / 1ps
module fdr_scoreboard import fdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [IDX_W-1:0]   cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  input  logic               out_tuser,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [REFL_W-1:0] refl;
    logic              tir;
  } refl_t;

  logic [IDX_W-1:0] n_inc, n_trn;
  refl_t            refl_q[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // |x-y|/(x+y) in Q31, both narrowed until the sum fits 32 bits
  function automatic logic [63:0] amp_ratio(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] s, d;
    s = x + y;
    while (s[63:32] != 0) begin
      x = x >> 1;
      y = y >> 1;
      s = x + y;
    end
    if (s == 0) return 64'd1 << 31;
    d = (x > y) ? x - y : y - x;
    return (d << 31) / s;
  endfunction

  function automatic refl_t fresnel(input logic [COS_W-1:0] raw);
    logic signed [COS_W-1:0] cs;
    logic [63:0] ni, nt, c, s2, lhs, rhs, e, qa, qb, sum, r;
    refl_t res;
    cs = raw;
    if (cs > 65536) cs = COS_W'(65536);
    if (cs < -65536) cs = COS_W'(-65536);
    ni = 64'(n_inc);
    nt = 64'(n_trn);
    if (cs > 0) begin
      c = 64'(cs);
    end else begin
      ni = 64'(n_trn);
      nt = 64'(n_inc);
      c = 64'(-cs);
    end
    s2  = (64'd1 << 32) - c * c;
    lhs = ni * ni * s2;
    rhs = (nt * nt) << 32;
    if (lhs >= rhs) begin
      res.refl = REFL_ONE;
      res.tir  = 1'b1;
      return res;
    end
    e   = int_sqrt(rhs - lhs);
    qa  = amp_ratio(nt * nt * c, ni * e);
    qb  = amp_ratio(ni * c, e);
    sum = qa * qa + qb * qb;
    r   = (sum + (64'd1 << 46)) >> 47;
    if (r > 64'd65536) r = 64'd65536;
    res.refl = r[REFL_W-1:0];
    res.tir  = 1'b0;
    return res;
  endfunction

  assign pending = refl_q.size();

  always @(posedge clk) begin
    refl_t want;
    if (!rst_n) begin
      n_inc  <= 16'd4096;
      n_trn  <= 16'd4096;
      errors <= 0;
      refl_q.delete();
    end else begin
      if (in_tvalid && in_tready) refl_q.push_back(fresnel(in_tdata[COS_W-1:0]));
      if (out_tvalid && out_tready) begin
        if (refl_q.size() == 0) begin
          $display("%0t: unexpected result refl=%0d tir=%0b", $time,
                   out_tdata[REFL_W-1:0], out_tuser);
          errors <= errors + 1;
        end else begin
          want = refl_q.pop_front();
          if (want.refl !== out_tdata[REFL_W-1:0] || want.tir !== out_tuser) begin
            $display("%0t: mismatch expected refl=%0d tir=%0b actual refl=%0d tir=%0b",
                     $time, want.refl, want.tir, out_tdata[REFL_W-1:0], out_tuser);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_INCIDENT) n_inc <= cfg_wdata;
        else                          n_trn <= cfg_wdata;
      end
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: stimulus, flow control and verdict for the Fresnel block.
`timescale 1ns / 1ps
module tb;
  import fdr_pkg::*;

  localparam int DRAIN_CYC = 120;     // covers the pipeline depth, plus slack
  localparam int MAX_CYC   = 600000;  // slow phases at 73% gaps, many times over

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_addr = 1'b0;
  logic [IDX_W-1:0]   cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;
  int                 errors, pending;
  int                 gap_pct = 0;    // sender idle chance per transaction
  int                 stall_pct = 0;  // receiver stall chance per cycle
  int                 cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fresnel_dielectric_reflectance uut (.*);

  fdr_scoreboard chk (.*);

  // receiver backpressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("fresnel_dielectric_reflectance regression: fail");
      $finish;
    end
  end

  // one input transaction, with optional idle gaps before it
  task automatic send_cos(input logic signed [COS_W-1:0] cosv);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(cosv[COS_W-1:0]) & {{(TDATA_W-COS_W){1'b0}}, {COS_W{1'b1}}};
    do @(posedge clk); while (!in_tready);
  endtask

  // empty the pipeline, then give it the full latency to settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_indices(input logic [IDX_W-1:0] ni, input logic [IDX_W-1:0] nt);
    cfg_we <= 1'b1; cfg_addr <= REG_INCIDENT; cfg_wdata <= ni;
    @(posedge clk);
    cfg_addr <= REG_TRANSMITTED; cfg_wdata <= nt;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly legal cosines, some over-range to hit the clamp
  function automatic logic signed [COS_W-1:0] rand_cos();
    case ($urandom_range(9))
      0:       return COS_W'($urandom);
      1:       return COS_W'(int'($urandom_range(6)) - 3);  // near grazing
      2:       return COS_W'(65536 - int'($urandom_range(64)));
      default: return COS_W'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  logic signed [COS_W-1:0] edge_cos[14] = '{0, 1, -1, 65536, -65536, 65535, -65535,
    131071, -131072, 70000, -70000, 32768, -32768, 46341};
  logic [IDX_W-1:0] ni_set[8] = '{4096, 4096, 6144, 1, 65535, 65535, 0, 5461};
  logic [IDX_W-1:0] nt_set[8] = '{4096, 6144, 4096, 65535, 1, 65535, 3000, 0};
  int gap_ph[4]   = '{0, 73, 0, 14};
  int stall_ph[4] = '{0, 0, 73, 14};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: edge cosines under reset indices, then air/glass both ways
    foreach (edge_cos[i]) send_cos(edge_cos[i]);
    drain();
    set_indices(16'd4096, 16'd6144);
    foreach (edge_cos[i]) send_cos(edge_cos[i]);
    drain();

    // random: every index setting, each under one of the flow-control phases
    for (int s = 0; s < 8; s++) begin
      set_indices(ni_set[s], nt_set[s]);
      gap_pct   = gap_ph[s % 4];
      stall_pct = stall_ph[s % 4];
      for (int k = 0; k < 88; k++) begin
        if (s == 2 && k == 44) drain();  // hold off until all results are back
        send_cos(rand_cos());
      end
      drain();
    end

    if (errors == 0) begin
      $display("fresnel_dielectric_reflectance regression: pass");
    end else begin
      $display("fresnel_dielectric_reflectance regression: fail");
    end
    $finish;
  end

endmodule
